FILE: rtl/bcat_pkg.sv
// Package for the block chain allocation table: op codes, sequencer steps,
// the control word layout and the microprogram table.
// No dependencies; the sequencer and datapath modules import it.
`default_nettype none

package bcat_pkg;

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_LINK  = 3'd1,
		OP_FREE  = 3'd2,
		OP_READ  = 3'd3,
		OP_LAST  = 3'd4,
		OP_AVAIL = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ALLOC0,
		ST_ALLOC,
		ST_AVAIL0,
		ST_AVAIL,
		ST_LINK,
		ST_FREE0,
		ST_FREE,
		ST_FREE_END,
		ST_READ,
		ST_LAST0,
		ST_LAST,
		ST_DONE
	} step_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_SCAN_EMPTY,
		C_NOT_IN_TABLE,
		C_FREE_HIT,
		C_SCAN_LAST,
		C_LINK_END,
		C_WALK_LAST,
		C_WALK_FULL,
		C_SPACE_NOW,
		C_SPACE_HIT,
		C_OUT_BUSY,
		C_CLEAR_LAST
	} cond_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_INC,
		PTR_NEXT
	} ptr_op_t;

	typedef struct packed {
		ptr_op_t ptr_op;
		logic    walk_inc;
		logic    used_set;
		logic    used_keep;
		logic    entry_clr;
		logic    link_wr;
		logic    acc_add;
		logic    cap_ptr;
		logic    cap_bi;
		logic    cap_entry;
		logic    set_end;
		logic    set_found;
		logic    set_space;
		logic    set_error;
		logic    load_out;
	} act_t;

	typedef struct packed {
		logic scan_empty;
		logic not_in_table;
		logic free_hit;
		logic scan_last;
		logic link_end;
		logic walk_last;
		logic walk_full;
		logic space_now;
		logic space_hit;
		logic out_busy;
		logic clear_last;
	} cond_vec_t;

	typedef struct packed {
		logic  dispatch;
		cond_t cond_a;
		step_t jump_a;
		act_t  act_a;
		cond_t cond_b;
		step_t jump_b;
		act_t  act_b;
		step_t next_f;
		act_t  act_f;
	} ucw_t;

	localparam act_t ACT_NONE = '0;

	function automatic step_t start_step(logic [2:0] op);
		step_t s;
		case (op_t'(op))
			OP_ALLOC: s = ST_ALLOC0;
			OP_LINK:  s = ST_LINK;
			OP_FREE:  s = ST_FREE0;
			OP_READ:  s = ST_READ;
			OP_LAST:  s = ST_LAST0;
			OP_AVAIL: s = ST_AVAIL0;
			default:  s = ST_DONE;
		endcase
		return s;
	endfunction

	function automatic ucw_t ucode(step_t s);
		ucw_t u;
		u = '0;
		case (s)
			ST_IDLE: begin
				u.dispatch = 1'b1;
				u.next_f = ST_IDLE;
			end
			ST_CLEAR: begin
				u.cond_a = C_CLEAR_LAST;
				u.jump_a = ST_IDLE;
				u.act_a.entry_clr = 1'b1;
				u.next_f = ST_CLEAR;
				u.act_f.entry_clr = 1'b1;
				u.act_f.ptr_op = PTR_INC;
			end
			ST_ALLOC0: begin
				u.cond_a = C_SCAN_EMPTY;
				u.jump_a = ST_DONE;
				u.next_f = ST_ALLOC;
				u.act_f.ptr_op = PTR_ZERO;
			end
			ST_ALLOC: begin
				u.cond_a = C_FREE_HIT;
				u.jump_a = ST_DONE;
				u.act_a.used_set = 1'b1;
				u.act_a.cap_ptr = 1'b1;
				u.act_a.set_found = 1'b1;
				u.cond_b = C_SCAN_LAST;
				u.jump_b = ST_DONE;
				u.next_f = ST_ALLOC;
				u.act_f.ptr_op = PTR_INC;
			end
			ST_AVAIL0: begin
				u.cond_a = C_SPACE_NOW;
				u.jump_a = ST_DONE;
				u.act_a.set_space = 1'b1;
				u.cond_b = C_SCAN_EMPTY;
				u.jump_b = ST_DONE;
				u.next_f = ST_AVAIL;
				u.act_f.ptr_op = PTR_ZERO;
			end
			ST_AVAIL: begin
				u.cond_a = C_SPACE_HIT;
				u.jump_a = ST_DONE;
				u.act_a.set_space = 1'b1;
				u.cond_b = C_SCAN_LAST;
				u.jump_b = ST_DONE;
				u.next_f = ST_AVAIL;
				u.act_f.acc_add = 1'b1;
				u.act_f.ptr_op = PTR_INC;
			end
			ST_LINK: begin
				u.cond_a = C_NOT_IN_TABLE;
				u.jump_a = ST_DONE;
				u.next_f = ST_DONE;
				u.act_f.link_wr = 1'b1;
			end
			ST_FREE0: begin
				u.cond_a = C_NOT_IN_TABLE;
				u.jump_a = ST_DONE;
				u.next_f = ST_FREE;
			end
			ST_FREE: begin
				u.cond_a = C_LINK_END;
				u.jump_a = ST_FREE_END;
				u.act_a.entry_clr = 1'b1;
				u.cond_b = C_WALK_LAST;
				u.jump_b = ST_FREE_END;
				u.act_b.entry_clr = 1'b1;
				u.act_b.set_error = 1'b1;
				u.next_f = ST_FREE;
				u.act_f.entry_clr = 1'b1;
				u.act_f.ptr_op = PTR_NEXT;
				u.act_f.walk_inc = 1'b1;
			end
			ST_FREE_END: begin
				u.next_f = ST_DONE;
				u.act_f.used_keep = 1'b1;
			end
			ST_READ: begin
				u.cond_a = C_NOT_IN_TABLE;
				u.jump_a = ST_DONE;
				u.act_a.set_end = 1'b1;
				u.next_f = ST_DONE;
				u.act_f.cap_entry = 1'b1;
			end
			ST_LAST0: begin
				u.cond_a = C_NOT_IN_TABLE;
				u.jump_a = ST_DONE;
				u.act_a.cap_bi = 1'b1;
				u.next_f = ST_LAST;
			end
			ST_LAST: begin
				u.cond_a = C_LINK_END;
				u.jump_a = ST_DONE;
				u.act_a.cap_ptr = 1'b1;
				u.cond_b = C_WALK_FULL;
				u.jump_b = ST_DONE;
				u.act_b.cap_ptr = 1'b1;
				u.act_b.set_error = 1'b1;
				u.next_f = ST_LAST;
				u.act_f.ptr_op = PTR_NEXT;
				u.act_f.walk_inc = 1'b1;
			end
			ST_DONE: begin
				u.cond_a = C_OUT_BUSY;
				u.jump_a = ST_DONE;
				u.next_f = ST_IDLE;
				u.act_f.load_out = 1'b1;
			end
			default: begin
				u.next_f = ST_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bcat_seq.sv
// Microcoded sequencer: step counter, control word table lookup and branch
// selection. Depends on bcat_pkg for the step, condition and action types.
`default_nettype none

module bcat_seq import bcat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  cond_vec_t  cond,
	output act_t       act,
	output logic       accept
);

	step_t step_q;
	step_t step_d;
	ucw_t  uc;
	logic  hit_a;
	logic  hit_b;

	function automatic logic cond_sel(cond_t c, cond_vec_t v);
		logic r;
		case (c)
			C_NEVER:        r = 1'b0;
			C_SCAN_EMPTY:   r = v.scan_empty;
			C_NOT_IN_TABLE: r = v.not_in_table;
			C_FREE_HIT:     r = v.free_hit;
			C_SCAN_LAST:    r = v.scan_last;
			C_LINK_END:     r = v.link_end;
			C_WALK_LAST:    r = v.walk_last;
			C_WALK_FULL:    r = v.walk_full;
			C_SPACE_NOW:    r = v.space_now;
			C_SPACE_HIT:    r = v.space_hit;
			C_OUT_BUSY:     r = v.out_busy;
			C_CLEAR_LAST:   r = v.clear_last;
			default:        r = 1'b0;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLEAR;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		uc = ucode(step_q);
		hit_a = cond_sel(uc.cond_a, cond);
		hit_b = cond_sel(uc.cond_b, cond);
		in_ready = uc.dispatch;
		accept = uc.dispatch & in_valid;
		act = ACT_NONE;
		step_d = step_q;
		if (uc.dispatch) begin
			if (in_valid) begin
				step_d = start_step(op);
			end
		end else if (hit_a) begin
			act = uc.act_a;
			step_d = uc.jump_a;
		end else if (hit_b) begin
			act = uc.act_b;
			step_d = uc.jump_b;
		end else begin
			act = uc.act_f;
			step_d = uc.next_f;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bcat_dp.sv
// Datapath: table memories, walk pointer and counters, configuration register,
// work result registers and the output register. Depends on bcat_pkg.
`default_nettype none

module bcat_dp import bcat_pkg::*; #(
	parameter int NUM_BLOCKS  = 4096,
	parameter int BLOCK_BYTES = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] table_entries,
	input  logic        accept,
	input  logic [11:0] block_index,
	input  logic [11:0] link_target,
	input  logic        link_to_end,
	input  logic        keep_first,
	input  logic [18:0] byte_count,
	input  act_t        act,
	output cond_vec_t   cond,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] result_index,
	output logic        found,
	output logic        entry_used,
	output logic [11:0] entry_next,
	output logic        entry_is_end,
	output logic        space_ok,
	output logic        chain_error
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int BW = $clog2(BLOCK_BYTES + 1);
	localparam int AW = ((BW > 19) ? BW : 19) + 1;

	typedef struct packed {
		logic          is_end;
		logic [IW-1:0] nxt;
	} link_ent_t;

	typedef struct packed {
		logic [11:0] index;
		logic        found;
		logic        used;
		logic [11:0] nxt;
		logic        is_end;
		logic        space;
		logic        error;
	} res_t;

	logic      used_mem [NUM_BLOCKS];
	link_ent_t link_mem [NUM_BLOCKS];

	logic [12:0]   entries_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] ptr_d;
	logic [CW-1:0] walk_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] acc_sum;
	logic [CW-1:0] scan_cnt;
	logic [11:0]   bi_q;
	logic [11:0]   lt_q;
	logic          to_end_q;
	logic          keep_q;
	logic [18:0]   bytes_q;
	logic          used_rd_q;
	link_ent_t     link_rd_q;
	res_t          res_q;
	res_t          out_q;
	logic          out_valid_q;

	logic          used_we;
	logic [IW-1:0] used_wa;
	logic          used_wd;
	logic          link_we;
	link_ent_t     link_wd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= 13'd4096;
		end else if (cfg_valid) begin
			entries_q <= table_entries;
		end
	end

	assign scan_cnt = (32'(entries_q) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(entries_q);
	assign acc_sum  = acc_q + (used_rd_q ? AW'(0) : AW'(BLOCK_BYTES));

	always_comb begin
		if (accept) begin
			ptr_d = IW'(block_index);
		end else begin
			case (act.ptr_op)
				PTR_HOLD: ptr_d = ptr_q;
				PTR_ZERO: ptr_d = '0;
				PTR_INC:  ptr_d = ptr_q + IW'(1);
				PTR_NEXT: ptr_d = link_rd_q.nxt;
				default:  ptr_d = ptr_q;
			endcase
		end
	end

	always_comb begin
		used_we = act.used_set | act.entry_clr | (act.used_keep & keep_q);
		used_wa = act.used_keep ? IW'(bi_q) : ptr_q;
		used_wd = act.used_set | act.used_keep;
		link_we = act.entry_clr | act.link_wr;
		link_wd.is_end = 1'b1;
		link_wd.nxt = '0;
		if (act.link_wr && !to_end_q && (32'(lt_q) < NUM_BLOCKS)) begin
			link_wd.is_end = 1'b0;
			link_wd.nxt = IW'(lt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		if (used_we && used_wa == ptr_d) begin
			used_rd_q <= used_wd;
		end else begin
			used_rd_q <= used_mem[ptr_d];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[ptr_q] <= link_wd;
		end
		if (link_we && ptr_q == ptr_d) begin
			link_rd_q <= link_wd;
		end else begin
			link_rd_q <= link_mem[ptr_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			ptr_q <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bi_q <= block_index;
			lt_q <= link_target;
			to_end_q <= link_to_end;
			keep_q <= keep_first;
			bytes_q <= byte_count;
			walk_q <= '0;
			acc_q <= '0;
			res_q <= '0;
		end else begin
			if (act.walk_inc) begin
				walk_q <= walk_q + CW'(1);
			end
			if (act.acc_add) begin
				acc_q <= acc_sum;
			end
			if (act.cap_ptr) begin
				res_q.index <= 12'(ptr_q);
			end
			if (act.cap_bi) begin
				res_q.index <= bi_q;
			end
			if (act.cap_entry) begin
				res_q.used <= used_rd_q;
				res_q.is_end <= link_rd_q.is_end;
				res_q.nxt <= link_rd_q.is_end ? 12'd0 : 12'(link_rd_q.nxt);
			end
			if (act.set_end) begin
				res_q.is_end <= 1'b1;
			end
			if (act.set_found) begin
				res_q.found <= 1'b1;
			end
			if (act.set_space) begin
				res_q.space <= 1'b1;
			end
			if (act.set_error) begin
				res_q.error <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (act.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act.load_out) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		cond.scan_empty = (scan_cnt == '0);
		cond.not_in_table = (32'(bi_q) >= NUM_BLOCKS);
		cond.free_hit = ~used_rd_q;
		cond.scan_last = ((CW'(ptr_q) + CW'(1)) == scan_cnt);
		cond.link_end = link_rd_q.is_end;
		cond.walk_last = (walk_q == CW'(NUM_BLOCKS - 1));
		cond.walk_full = (walk_q == CW'(NUM_BLOCKS));
		cond.space_now = (acc_q >= AW'(bytes_q));
		cond.space_hit = (acc_sum >= AW'(bytes_q));
		cond.out_busy = out_valid_q & ~out_ready;
		cond.clear_last = (ptr_q == IW'(NUM_BLOCKS - 1));
	end

	assign out_valid    = out_valid_q;
	assign result_index = out_q.index;
	assign found        = out_q.found;
	assign entry_used   = out_q.used;
	assign entry_next   = out_q.nxt;
	assign entry_is_end = out_q.is_end;
	assign space_ok     = out_q.space;
	assign chain_error  = out_q.error;

endmodule

`default_nettype wire

FILE: rtl/block_chain_allocation_table_unit.sv
// Block chain allocation table: a table of blocks with used bits and next
// links, run by a microcoded sequencer. Top level; depends on bcat_pkg,
// bcat_seq and bcat_dp.
//
// Each input transaction carries an op code and its operands and produces
// exactly one output transaction. The configuration channel writes the entry
// count used by the allocate search and the availability count; it is always
// ready and should be written only while the block is idle.
// Work per item: read and link touch a single table entry, and unused op codes
// go straight to the done step. Allocate and availability scan the table
// entries in order; free chain and last of chain follow the links block by
// block. The sequencer steps through one table entry per cycle on the single
// read port of the table. One item is in work at a time; a new item is taken
// as soon as the previous one has reached the output register.
// After reset the table is cleared one entry a cycle, every entry in turn,
// while input ready stays low. A stalled receiver holds the result in the
// output register; the next item then finishes its work and waits in the done
// step until the output register is free.
`default_nettype none

module block_chain_allocation_table_unit import bcat_pkg::*; #(
	parameter int NUM_BLOCKS  = 4096,
	parameter int BLOCK_BYTES = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] table_entries,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [11:0] block_index,
	input  logic [11:0] link_target,
	input  logic        link_to_end,
	input  logic        keep_first,
	input  logic [18:0] byte_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] result_index,
	output logic        found,
	output logic        entry_used,
	output logic [11:0] entry_next,
	output logic        entry_is_end,
	output logic        space_ok,
	output logic        chain_error
);

	act_t      act;
	cond_vec_t cond;
	logic      accept;

	bcat_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.cond     (cond),
		.act      (act),
		.accept   (accept)
	);

	bcat_dp #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.table_entries (table_entries),
		.accept        (accept),
		.block_index   (block_index),
		.link_target   (link_target),
		.link_to_end   (link_to_end),
		.keep_first    (keep_first),
		.byte_count    (byte_count),
		.act           (act),
		.cond          (cond),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_index  (result_index),
		.found         (found),
		.entry_used    (entry_used),
		.entry_next    (entry_next),
		.entry_is_end  (entry_is_end),
		.space_ok      (space_ok),
		.chain_error   (chain_error)
	);

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for block_chain_allocation_table_unit:
// ops, entry counts and flow control, each accepted transaction predicted
// by an in-bench table model. Depends on bcat_pkg and the RTL of the block only.
module tb_top import bcat_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK = 4096;
	localparam int BYTES_PER_BLOCK = 100;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int REPORT_LIMIT = 10;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] blk;
		logic [11:0] target;
		logic        to_end;
		logic        keep;
		logic [18:0] bytes;
	} table_req_t;

	typedef struct packed {
		logic [11:0] result_index;
		logic        found;
		logic        entry_used;
		logic [11:0] entry_next;
		logic        entry_is_end;
		logic        space_ok;
		logic        chain_error;
	} table_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] table_entries;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [11:0] block_index;
	logic [11:0] link_target;
	logic        link_to_end;
	logic        keep_first;
	logic [18:0] byte_count;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] result_index;
	logic        found;
	logic        entry_used;
	logic [11:0] entry_next;
	logic        entry_is_end;
	logic        space_ok;
	logic        chain_error;

	block_chain_allocation_table_unit #(
		.NUM_BLOCKS(NBLK),
		.BLOCK_BYTES(BYTES_PER_BLOCK)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.table_entries(table_entries),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.block_index(block_index),
		.link_target(link_target),
		.link_to_end(link_to_end),
		.keep_first(keep_first),
		.byte_count(byte_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_index(result_index),
		.found(found),
		.entry_used(entry_used),
		.entry_next(entry_next),
		.entry_is_end(entry_is_end),
		.space_ok(space_ok),
		.chain_error(chain_error)
	);

	// Mirror of the allocation table and its entry-count register.
	bit          used_map [NBLK];
	logic [11:0] link_map [NBLK];
	bit          end_map [NBLK];
	logic [12:0] entry_limit;

	table_rsp_t pending_results[$];
	table_rsp_t last_rsp;
	int         error_cnt;
	int         results_checked;
	int         cfg_writes;
	int         op_seen [8];
	int         burst_left;
	bit         sender_steady;
	bit         rx_steady;
	int         hold_request;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Run stopped by the time limit with %0d results pending.",
			pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic table_rsp_t apply_table_op(table_req_t rq);
		table_rsp_t  rs;
		int unsigned lim, k, need, nfree;
		logic [11:0] cur, nx;
		bit          more;
		rs = '0;
		lim = (entry_limit > NBLK) ? NBLK : entry_limit;
		case (rq.op)
			OP_ALLOC: begin
				for (k = 0; k < lim; k++) begin
					if (!used_map[k]) begin
						used_map[k] = 1'b1;
						rs.result_index = k[11:0];
						rs.found = 1'b1;
						break;
					end
				end
			end
			OP_LINK: begin
				if (rq.blk < NBLK) begin
					if (rq.to_end || rq.target >= NBLK) begin
						end_map[rq.blk] = 1'b1;
						link_map[rq.blk] = '0;
					end else begin
						end_map[rq.blk] = 1'b0;
						link_map[rq.blk] = rq.target;
					end
				end
			end
			OP_FREE: begin
				if (rq.blk < NBLK) begin
					more = 1'b1;
					cur = rq.blk;
					for (k = 0; k < NBLK && more; k++) begin
						more = !end_map[cur];
						nx = link_map[cur];
						end_map[cur] = 1'b1;
						link_map[cur] = '0;
						used_map[cur] = 1'b0;
						if (more)
							cur = nx;
					end
					rs.chain_error = more;
					if (rq.keep)
						used_map[rq.blk] = 1'b1;
				end
			end
			OP_READ: begin
				if (rq.blk < NBLK) begin
					rs.entry_used = used_map[rq.blk];
					rs.entry_is_end = end_map[rq.blk];
					rs.entry_next = end_map[rq.blk] ? 12'd0 : link_map[rq.blk];
				end else begin
					rs.entry_is_end = 1'b1;
				end
			end
			OP_LAST: begin
				cur = rq.blk;
				for (k = 0; k < NBLK && cur < NBLK && !end_map[cur]; k++)
					cur = link_map[cur];
				rs.chain_error = (cur < NBLK) && !end_map[cur];
				rs.result_index = cur;
			end
			OP_AVAIL: begin
				need = rq.bytes / BYTES_PER_BLOCK;
				if (rq.bytes % BYTES_PER_BLOCK != 0)
					need++;
				nfree = 0;
				for (k = 0; k < lim && nfree < need; k++)
					if (!used_map[k])
						nfree++;
				rs.space_ok = (nfree == need);
			end
			default: begin
			end
		endcase
		return rs;
	endfunction

	function automatic table_req_t mk(logic [2:0] o, int blk, int tgt, int te, int kf,
		int bytes);
		table_req_t rq;
		rq.op = o;
		rq.blk = blk[11:0];
		rq.target = tgt[11:0];
		rq.to_end = te[0];
		rq.keep = kf[0];
		rq.bytes = bytes[18:0];
		return rq;
	endfunction

	task automatic send_item(table_req_t rq);
		int gap;
		gap = 0;
		if (!sender_steady) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		op = rq.op;
		block_index = rq.blk;
		link_target = rq.target;
		link_to_end = rq.to_end;
		keep_first = rq.keep;
		byte_count = rq.bytes;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		last_rsp = apply_table_op(rq);
		pending_results.push_back(last_rsp);
		op_seen[rq.op]++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_entry_count(logic [12:0] val);
		drain_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		table_entries = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		entry_limit = val;
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		table_rsp_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.result_index = result_index;
			got.found = found;
			got.entry_used = entry_used;
			got.entry_next = entry_next;
			got.entry_is_end = entry_is_end;
			got.space_ok = space_ok;
			got.chain_error = chain_error;
			if (pending_results.size() == 0) begin
				if (error_cnt < REPORT_LIMIT)
					$display("%0t: output transaction with nothing expected: %p", $realtime, got);
				error_cnt++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.result_index !== want.result_index || got.found !== want.found ||
					got.entry_used !== want.entry_used || got.entry_next !== want.entry_next ||
					got.entry_is_end !== want.entry_is_end || got.space_ok !== want.space_ok ||
					got.chain_error !== want.chain_error) begin
					if (error_cnt < REPORT_LIMIT)
						$display("%0t: result %0d expected %p got %p", $realtime,
							results_checked, want, got);
					error_cnt++;
				end
			end
		end
	end

	// Output side: random 16-bit stall patterns or steady ready, plus long hold-offs on request.
	initial begin : drive_out_ready
		int        hold_left, mode;
		logic [3:0] pat_pos;
		bit [15:0] pat;
		out_ready = 1'b0;
		hold_left = 0;
		pat_pos = 4'd0;
		pat = '1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (rx_steady) begin
				out_ready = 1'b1;
			end else begin
				if (pat_pos == 4'd0) begin
					mode = $urandom_range(0, 3);
					if (mode == 0)
						pat = '1;
					else if (mode == 3)
						pat = 16'($urandom & $urandom);
					else
						pat = 16'($urandom);
				end
				out_ready = pat[pat_pos];
				pat_pos = pat_pos + 4'd1;
			end
		end
	end

	task automatic test_directed_ops();
		send_item(mk(OP_READ, 0, 0, 0, 0, 0));
		send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
		send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
		send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
		send_item(mk(OP_LINK, 0, 1, 0, 0, 0));
		send_item(mk(OP_LINK, 1, 2, 0, 0, 0));
		send_item(mk(OP_LINK, 2, 4095, 1, 0, 0));
		send_item(mk(OP_READ, 0, 0, 0, 0, 0));
		send_item(mk(OP_READ, 4095, 0, 0, 0, 0));
		send_item(mk(OP_LAST, 0, 0, 0, 0, 0));
		send_item(mk(OP_LAST, 4095, 0, 0, 0, 0));
		// Closing the chain into a loop makes the walk run to its bound.
		send_item(mk(OP_LINK, 2, 0, 0, 0, 0));
		send_item(mk(OP_LAST, 1, 0, 0, 0, 0));
		send_item(mk(OP_FREE, 0, 0, 0, 1, 0));
		send_item(mk(OP_READ, 0, 0, 0, 0, 0));
		send_item(mk(OP_READ, 2, 0, 0, 0, 0));
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 0));
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 101));
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 409600));
		send_item(mk(OP_SPARE6, 4095, 4095, 1, 1, 409600));
		send_item(mk(OP_SPARE7, 4095, 4095, 1, 1, 409599));
		send_item(mk(OP_LINK, 4095, 4095, 0, 0, 0));
		send_item(mk(OP_READ, 4095, 0, 0, 0, 0));
		send_item(mk(OP_LAST, 4095, 0, 0, 0, 0));
		send_item(mk(OP_FREE, 4095, 0, 0, 0, 0));
	endtask

	task automatic test_entry_limits();
		write_entry_count(13'd0);
		send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 0));
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 1));
		write_entry_count(13'h1fff);
		send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 409500));
		write_entry_count(13'd1);
		send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 100));
		send_item(mk(OP_FREE, 1, 0, 0, 0, 0));
	endtask

	task automatic test_backpressure();
		write_entry_count(13'd32);
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 6; i++)
			send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
		drain_results();
		sender_steady = 1'b1;
		rx_steady = 1'b1;
		for (int i = 0; i < 8; i++)
			send_item(mk((i % 2) ? OP_READ : OP_AVAIL, i, 0, 0, 0, i * 150));
		drain_results();
		sender_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	function automatic int pick_block();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, NBLK - 1) : $urandom_range(0, 63);
	endfunction

	task automatic send_noise_item();
		int bytes;
		bytes = $urandom_range(0, 1) ? $urandom_range(0, 6400) : $urandom_range(0, 409600);
		send_item(mk(3'($urandom_range(0, 7)), pick_block(), pick_block(),
			$urandom_range(0, 1), $urandom_range(0, 1), bytes));
	endtask

	// Allocates a short chain, links it, inspects it and usually frees it again.
	task automatic run_file_sequence(inout int sent);
		int blocks[$];
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			send_item(mk(OP_ALLOC, 0, 0, 0, 0, 0));
			sent++;
			if (last_rsp.found)
				blocks.push_back(last_rsp.result_index);
		end
		if (blocks.size() == 0) begin
			send_item(mk(OP_FREE, $urandom_range(0, 15), 0, 0, 0, 0));
			sent++;
			return;
		end
		for (int i = 0; i < blocks.size(); i++) begin
			if (i == blocks.size() - 1)
				send_item(mk(OP_LINK, blocks[i], pick_block(), 1, 0, 0));
			else
				send_item(mk(OP_LINK, blocks[i], blocks[i + 1], 0, 0, 0));
			sent++;
		end
		send_item(mk(OP_READ, blocks[$urandom_range(0, blocks.size() - 1)], 0, 0, 0, 0));
		send_item(mk(OP_LAST, blocks[0], 0, 0, 0, 0));
		sent += 2;
		if ($urandom_range(0, 1)) begin
			send_item(mk(OP_AVAIL, 0, 0, 0, 0, $urandom_range(0, 6400)));
			sent++;
		end
		if ($urandom_range(0, 9) < 7) begin
			send_item(mk(OP_FREE, blocks[0], 0, 0, $urandom_range(0, 1), 0));
			sent++;
		end
	endtask

	task automatic test_random_traffic();
		logic [12:0] limits [4];
		int sent;
		limits[0] = 13'd16;
		limits[1] = 13'($urandom_range(2, 64));
		limits[2] = 13'd4095;
		limits[3] = 13'd40;
		foreach (limits[p]) begin
			write_entry_count(limits[p]);
			sent = 0;
			while (sent < 20) begin
				if ($urandom_range(0, 3) == 0) begin
					send_noise_item();
					sent++;
				end else begin
					run_file_sequence(sent);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		table_entries = '0;
		in_valid = 1'b0;
		op = '0;
		block_index = '0;
		link_target = '0;
		link_to_end = 1'b0;
		keep_first = 1'b0;
		byte_count = '0;
		error_cnt = 0;
		results_checked = 0;
		cfg_writes = 0;
		burst_left = 0;
		sender_steady = 1'b0;
		rx_steady = 1'b0;
		hold_request = 0;
		foreach (op_seen[i])
			op_seen[i] = 0;
		foreach (used_map[i]) begin
			used_map[i] = 1'b0;
			link_map[i] = '0;
			end_map[i] = 1'b1;
		end
		entry_limit = 13'd4096;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);

		test_directed_ops();
		test_entry_limits();
		test_backpressure();
		test_random_traffic();
		write_entry_count(13'd4096);
		send_item(mk(OP_AVAIL, 0, 0, 0, 0, 409600));

		drain_results();
		repeat (16) @(posedge clk);
		if (pending_results.size() != 0)
			error_cnt++;
		$display("Covered alloc %0d, link %0d, free %0d, read %0d, last %0d, avail %0d, spare %0d.",
			op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
			op_seen[6] + op_seen[7]);
		$display("Checked %0d results over %0d entry-count writes; %0d failures.",
			results_checked, cfg_writes, error_cnt);
		if (error_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
